/* rtl/rbaa_pkg.sv */
// Shared constants, register and mode codes, and helpers for the angular acceleration block.
package rbaa_pkg;

  localparam int DATA_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;

  // Pipelined multiplier: limb width of the partial products and stage count.
  localparam int MUL_LIMB = 32;
  localparam int MUL_LAT  = 5;

  // Reset value of the diagonal moments (1.0 in Q16.16).
  localparam int INERTIA_RST = 65536;

  localparam logic [2:0] MODE_FULL      = 3'd0;
  localparam logic [2:0] MODE_PLANE     = 3'd1;
  localparam logic [2:0] MODE_PRINCIPAL = 3'd2;
  localparam logic [2:0] MODE_AXISYM    = 3'd3;
  localparam logic [2:0] MODE_EQUAL     = 3'd4;

  localparam logic [2:0] REG_MODE = 3'd0;
  localparam logic [2:0] REG_IXX  = 3'd1;
  localparam logic [2:0] REG_IYY  = 3'd2;
  localparam logic [2:0] REG_IZZ  = 3'd3;
  localparam logic [2:0] REG_PXY  = 3'd4;
  localparam logic [2:0] REG_PXZ  = 3'd5;
  localparam logic [2:0] REG_PYZ  = 3'd6;

  function automatic int max2(input int x, input int y);
    return (x > y) ? x : y;
  endfunction

endpackage

/* rtl/rbaa_mul.sv */
// Pipelined signed multiplier built from limb-sized partial products.
module rbaa_mul #(
  parameter int AW = 33,
  parameter int BW = 32
) (
  input  logic                          clk,
  input  logic [rbaa_pkg::MUL_LAT-1:0]  en,
  input  logic signed [AW-1:0]          a,
  input  logic signed [BW-1:0]          b,
  output logic signed [AW+BW-1:0]       p
);
  import rbaa_pkg::*;

  localparam int NA = (AW + MUL_LIMB - 1) / MUL_LIMB;
  localparam int NB = (BW + MUL_LIMB - 1) / MUL_LIMB;
  localparam int AP = NA * MUL_LIMB;
  localparam int BP = NB * MUL_LIMB;
  localparam int PW = AW + BW;
  localparam int RW = (NB + 1) * MUL_LIMB;
  localparam int TW = (NA + NB + 1) * MUL_LIMB;

  logic [AW-1:0]           a_abs;
  logic [BW-1:0]           b_abs;
  logic [AP-1:0]           am;
  logic [BP-1:0]           bm;
  logic [MUL_LAT-2:0]      neg;
  logic [2*MUL_LIMB-1:0]   pp [NA][NB];
  logic [RW-1:0]           row [NA];
  logic [RW-1:0]           row_next [NA];
  logic [TW-1:0]           acc;
  logic [PW-1:0]           tot;

  always_comb begin
    a_abs = a[AW-1] ? AW'(-a) : AW'(a);
    b_abs = b[BW-1] ? BW'(-b) : BW'(b);
  end

  always_comb begin
    for (int i = 0; i < NA; i++) begin
      row_next[i] = '0;
      for (int j = 0; j < NB; j++) begin
        row_next[i] = row_next[i] + (RW'(pp[i][j]) << (j * MUL_LIMB));
      end
    end
  end

  always_comb begin
    acc = '0;
    for (int i = 0; i < NA; i++) begin
      acc = acc + (TW'(row[i]) << (i * MUL_LIMB));
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      am     <= AP'(a_abs);
      bm     <= BP'(b_abs);
      neg[0] <= a[AW-1] ^ b[BW-1];
    end
    if (en[1]) begin
      for (int i = 0; i < NA; i++) begin
        for (int j = 0; j < NB; j++) begin
          pp[i][j] <= am[i*MUL_LIMB +: MUL_LIMB] * bm[j*MUL_LIMB +: MUL_LIMB];
        end
      end
      neg[1] <= neg[0];
    end
    if (en[2]) begin
      for (int i = 0; i < NA; i++) row[i] <= row_next[i];
      neg[2] <= neg[1];
    end
    if (en[3]) begin
      tot    <= acc[PW-1:0];
      neg[3] <= neg[2];
    end
    if (en[4]) begin
      p <= neg[3] ? -$signed(tot) : $signed(tot);
    end
  end

endmodule

/* rtl/rbaa_div.sv */
// Pipelined restoring divider lane: one quotient bit per stage, truncating and saturating.
module rbaa_div #(
  parameter int DW  = 32,
  parameter int FB  = 16,
  parameter int NW  = 170,
  parameter int DNW = 102
) (
  input  logic                  clk,
  input  logic [DW+2:0]         en,
  input  logic signed [NW-1:0]  num,
  input  logic signed [DNW-1:0] den,
  output logic signed [DW-1:0]  quo,
  output logic                  fault
);
  import rbaa_pkg::*;

  localparam int DDW = DNW + FB;
  localparam int CW  = max2(NW, DDW + DW + 1) + 1;
  localparam int QB  = DW + 1;

  logic [NW-1:0]   num_abs;
  logic [DNW-1:0]  den_abs;
  logic [CW-1:0]   rem [QB+1];
  logic [DDW-1:0]  dvs [QB+1];
  logic [QB-1:0]   qb [QB+1];
  logic [QB:0]     neg;
  logic [QB:0]     zero;
  logic [QB:0]     nneg;
  logic [CW:0]     diff [QB];
  logic [QB-1:0]   lim;
  logic [DW-1:0]   maxpos;
  logic [DW-1:0]   minneg;

  always_comb begin
    num_abs = num[NW-1] ? NW'(-num) : NW'(num);
    den_abs = den[DNW-1] ? DNW'(-den) : DNW'(den);
  end

  // Stage s tries the divisor shifted to quotient bit QB-s; the first of these
  // stages marks a quotient too large for the output range.
  always_comb begin
    for (int s = 1; s <= QB; s++) begin
      diff[s-1] = {1'b0, rem[s-1]} - {1'b0, (CW'(dvs[s-1]) << (QB - s))};
    end
  end

  always_comb begin
    maxpos = {1'b0, {(DW-1){1'b1}}};
    minneg = {1'b1, {(DW-1){1'b0}}};
    lim    = neg[QB] ? QB'(minneg) : QB'(maxpos);
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      rem[0]  <= CW'(num_abs);
      dvs[0]  <= {den_abs, {FB{1'b0}}};
      qb[0]   <= '0;
      neg[0]  <= num[NW-1] ^ den[DNW-1];
      zero[0] <= (den == '0);
      nneg[0] <= num[NW-1];
    end
    for (int s = 1; s <= QB; s++) begin
      if (en[s]) begin
        rem[s]  <= diff[s-1][CW] ? rem[s-1] : diff[s-1][CW-1:0];
        qb[s]   <= {qb[s-1][QB-2:0], !diff[s-1][CW]};
        dvs[s]  <= dvs[s-1];
        neg[s]  <= neg[s-1];
        zero[s] <= zero[s-1];
        nneg[s] <= nneg[s-1];
      end
    end
    if (en[QB+1]) begin
      fault <= zero[QB];
      if (zero[QB]) begin
        quo <= nneg[QB] ? minneg : maxpos;
      end else if (qb[QB] > lim) begin
        quo <= neg[QB] ? minneg : maxpos;
      end else begin
        quo <= neg[QB] ? -qb[QB][DW-1:0] : qb[QB][DW-1:0];
      end
    end
  end

endmodule

/* rtl/rigid_body_angular_acceleration.sv */
// Top level: Euler rotation equations solved for angular acceleration in a deep pipeline.
//
// Items enter on the item channel (omega and torque, valid/ready) and leave on the
// result channel (alpha and divide_fault, valid/ready). Every stage carries a valid
// bit and advances when it is empty or the stage after it advances, so one item is
// taken per cycle unless a stalled receiver has let every stage fill, and bubbles
// close up behind a stalled receiver. An input register is followed by three
// five-stage multiplier groups (inertia times omega and adjugate terms, gyroscopic
// cross terms and the determinant, adjugate times right-hand side), each with a
// summing stage behind it, and a divider lane per axis that resolves one quotient
// bit per stage plus an overflow bit. Throughput is one item per cycle while the
// receiver takes results. When the receiver stalls, the pipeline fills up and
// item_ready falls only once every stage holds an item.
// Reset empties the pipeline and loads the register defaults: full mode, unit diagonal
// moments and zero products. The APB port writes the symmetry mode and the inertia terms;
// the user must change these only while no item is in flight; the block does not check.
module rigid_body_angular_acceleration #(
  parameter int  DATA_WIDTH = rbaa_pkg::DATA_WIDTH_DEF,
  parameter int  FRAC_BITS  = rbaa_pkg::FRAC_BITS_DEF,
  localparam int APB_DW     = (DATA_WIDTH > 32) ? 64 : 32,
  localparam int APB_AW     = 3 + $clog2(APB_DW / 8)
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [APB_AW-1:0]            paddr,
  input  logic [APB_DW-1:0]            pwdata,
  output logic [APB_DW-1:0]            prdata,
  output logic                         pready,
  input  logic                         item_valid,
  output logic                         item_ready,
  input  logic signed [DATA_WIDTH-1:0] omega_x,
  input  logic signed [DATA_WIDTH-1:0] omega_y,
  input  logic signed [DATA_WIDTH-1:0] omega_z,
  input  logic signed [DATA_WIDTH-1:0] torque_x,
  input  logic signed [DATA_WIDTH-1:0] torque_y,
  input  logic signed [DATA_WIDTH-1:0] torque_z,
  output logic                         result_valid,
  input  logic                         result_ready,
  output logic signed [DATA_WIDTH-1:0] alpha_x,
  output logic signed [DATA_WIDTH-1:0] alpha_y,
  output logic signed [DATA_WIDTH-1:0] alpha_z,
  output logic                         divide_fault
);
  import rbaa_pkg::*;

  localparam int DW  = DATA_WIDTH;
  localparam int FB  = FRAC_BITS;
  localparam int MW  = DW + 1;
  localparam int P1W = MW + DW;
  localparam int IWW = P1W + 2;
  localparam int P2W = 2 * MW;
  localparam int ADW = P2W + 1;
  localparam int P3W = DW + IWW;
  localparam int P4W = MW + ADW;
  localparam int RHW = max2(P3W, DW + 2 * FB) + 2;
  localparam int DTW = P4W + 2;
  localparam int P5W = ADW + RHW;
  localparam int NW  = P5W + 2;

  localparam int DIV_LAT = DW + 3;
  localparam int G1  = 1;
  localparam int S6  = G1 + MUL_LAT;
  localparam int G2  = S6 + 1;
  localparam int S12 = G2 + MUL_LAT;
  localparam int G3  = S12 + 1;
  localparam int S18 = G3 + MUL_LAT;
  localparam int GD  = S18 + 1;
  localparam int NS  = GD + DIV_LAT;

  // Cross product operands: rhs_i subtracts w[CW_IDX[2i]]*iw[CI_IDX[2i]] and adds
  // w[CW_IDX[2i+1]]*iw[CI_IDX[2i+1]].
  localparam int CW_IDX [6] = '{1, 2, 2, 0, 0, 1};
  localparam int CI_IDX [6] = '{2, 1, 0, 2, 1, 0};
  // Adjugate storage order is 00, 11, 22, 01, 02, 12; the matrix is symmetric.
  localparam int ADJ_IDX [3][3] = '{'{0, 3, 4}, '{3, 1, 5}, '{4, 5, 2}};

  typedef struct {
    logic signed [DW-1:0] w [3];
    logic signed [DW-1:0] t [3];
    logic signed [MW-1:0] a, b, c, d, e, f;
    logic                 dmode;
  } s0_t;

  typedef struct {
    logic signed [DW-1:0]  w [3];
    logic signed [DW-1:0]  t [3];
    logic signed [IWW-1:0] iw [3];
    logic signed [ADW-1:0] adj [6];
    logic signed [MW-1:0]  a, b, c, d, e;
    logic                  dmode;
  } s6_t;

  typedef struct {
    logic signed [RHW-1:0] rhs [3];
    logic signed [ADW-1:0] adj [6];
    logic signed [DTW-1:0] det;
    logic signed [MW-1:0]  a, b, c;
    logic                  dmode;
  } s12_t;

  typedef struct {
    logic signed [NW-1:0]  num [3];
    logic signed [DTW-1:0] den [3];
  } s18_t;

  // Configuration registers.
  logic [2:0]      mode;
  logic [DW-2:0]   ixx, iyy, izz;
  logic [DW-1:0]   pxy, pxz, pyz;
  logic [2:0]      cfg_idx;
  logic            cfg_wr;

  // Pipeline control.
  logic [NS-1:0]   v;
  logic [NS-1:0]   en;

  // Matrix for the current mode.
  logic signed [MW-1:0] xx, yy, zz, nxy, nxz, nyz;
  logic signed [MW-1:0] ma, mb, mc, md, me, mf;
  logic                 dmode;

  s0_t  side1 [MUL_LAT+1];
  s6_t  side2 [MUL_LAT+1];
  s12_t side3 [MUL_LAT+1];
  s18_t st18;

  logic signed [MW-1:0]  m1 [3][3];
  logic signed [MW-1:0]  adj_a [12];
  logic signed [MW-1:0]  adj_b [12];
  logic signed [P1W-1:0] p_iw [3][3];
  logic signed [P2W-1:0] p_adj [12];
  logic signed [P3W-1:0] p_cr [6];
  logic signed [P4W-1:0] p_det [3];
  logic signed [P5W-1:0] p_n [3][3];
  logic signed [DW-1:0]  quo [3];
  logic [2:0]            flt;

  // ---------------------------------------------------------------- config port
  assign cfg_idx = paddr[APB_AW-1 -: 3];
  assign cfg_wr  = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_FULL;
      ixx  <= (DW-1)'(INERTIA_RST);
      iyy  <= (DW-1)'(INERTIA_RST);
      izz  <= (DW-1)'(INERTIA_RST);
      pxy  <= '0;
      pxz  <= '0;
      pyz  <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_MODE: mode <= pwdata[2:0];
        REG_IXX:  ixx  <= pwdata[DW-2:0];
        REG_IYY:  iyy  <= pwdata[DW-2:0];
        REG_IZZ:  izz  <= pwdata[DW-2:0];
        REG_PXY:  pxy  <= pwdata[DW-1:0];
        REG_PXZ:  pxz  <= pwdata[DW-1:0];
        REG_PYZ:  pyz  <= pwdata[DW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_MODE: prdata = APB_DW'(mode);
      REG_IXX:  prdata = APB_DW'(ixx);
      REG_IYY:  prdata = APB_DW'(iyy);
      REG_IZZ:  prdata = APB_DW'(izz);
      REG_PXY:  prdata = APB_DW'(pxy);
      REG_PXZ:  prdata = APB_DW'(pxz);
      REG_PYZ:  prdata = APB_DW'(pyz);
      default:  prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- control
  always_comb begin
    en[NS-1] = !v[NS-1] || result_ready;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = !v[k] || en[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) v[0] <= item_valid;
      for (int k = 1; k < NS; k++) begin
        if (en[k]) v[k] <= v[k-1];
      end
    end
  end

  assign item_ready   = en[0];
  assign result_valid = v[NS-1];

  // ---------------------------------------------------------------- matrix
  always_comb begin
    xx  = MW'(ixx);
    yy  = MW'(iyy);
    zz  = MW'(izz);
    // Products of inertia enter the matrix negated.
    nxy = -$signed({pxy[DW-1], pxy});
    nxz = -$signed({pxz[DW-1], pxz});
    nyz = -$signed({pyz[DW-1], pyz});
    ma = xx;
    mb = yy;
    mc = zz;
    md = nxy;
    me = nxz;
    mf = nyz;
    dmode = 1'b0;
    unique case (mode)
      MODE_PLANE: begin
        md = '0;
        mf = '0;
      end
      MODE_PRINCIPAL: begin
        md = '0;
        me = '0;
        mf = '0;
        dmode = 1'b1;
      end
      MODE_AXISYM: begin
        mc = yy;
        md = '0;
        me = '0;
        mf = '0;
        dmode = 1'b1;
      end
      MODE_EQUAL: begin
        mb = xx;
        mc = xx;
        md = '0;
        me = '0;
        mf = '0;
        dmode = 1'b1;
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------- stage 0
  always_ff @(posedge clk) begin
    if (en[0]) begin
      side1[0].w[0]  <= omega_x;
      side1[0].w[1]  <= omega_y;
      side1[0].w[2]  <= omega_z;
      side1[0].t[0]  <= torque_x;
      side1[0].t[1]  <= torque_y;
      side1[0].t[2]  <= torque_z;
      side1[0].a     <= ma;
      side1[0].b     <= mb;
      side1[0].c     <= mc;
      side1[0].d     <= md;
      side1[0].e     <= me;
      side1[0].f     <= mf;
      side1[0].dmode <= dmode;
    end
    for (int s = 1; s <= MUL_LAT; s++) begin
      if (en[G1+s-1]) side1[s] <= side1[s-1];
    end
  end

  // ---------------------------------------------------------------- group 1
  always_comb begin
    m1[0][0] = side1[0].a;
    m1[0][1] = side1[0].d;
    m1[0][2] = side1[0].e;
    m1[1][0] = side1[0].d;
    m1[1][1] = side1[0].b;
    m1[1][2] = side1[0].f;
    m1[2][0] = side1[0].e;
    m1[2][1] = side1[0].f;
    m1[2][2] = side1[0].c;
    // Pairs for the adjugate: bc ff, ac ee, ab dd, ef dc, df be, de af.
    adj_a[0]  = side1[0].b;  adj_b[0]  = side1[0].c;
    adj_a[1]  = side1[0].f;  adj_b[1]  = side1[0].f;
    adj_a[2]  = side1[0].a;  adj_b[2]  = side1[0].c;
    adj_a[3]  = side1[0].e;  adj_b[3]  = side1[0].e;
    adj_a[4]  = side1[0].a;  adj_b[4]  = side1[0].b;
    adj_a[5]  = side1[0].d;  adj_b[5]  = side1[0].d;
    adj_a[6]  = side1[0].e;  adj_b[6]  = side1[0].f;
    adj_a[7]  = side1[0].d;  adj_b[7]  = side1[0].c;
    adj_a[8]  = side1[0].d;  adj_b[8]  = side1[0].f;
    adj_a[9]  = side1[0].b;  adj_b[9]  = side1[0].e;
    adj_a[10] = side1[0].d;  adj_b[10] = side1[0].e;
    adj_a[11] = side1[0].a;  adj_b[11] = side1[0].f;
  end

  for (genvar i = 0; i < 3; i++) begin : g_iw_row
    for (genvar j = 0; j < 3; j++) begin : g_iw_col
      rbaa_mul #(.AW(MW), .BW(DW)) u_mul (
        .clk (clk),
        .en  (en[G1 +: MUL_LAT]),
        .a   (m1[i][j]),
        .b   (side1[0].w[j]),
        .p   (p_iw[i][j])
      );
    end
  end

  for (genvar k = 0; k < 12; k++) begin : g_adj
    rbaa_mul #(.AW(MW), .BW(MW)) u_mul (
      .clk (clk),
      .en  (en[G1 +: MUL_LAT]),
      .a   (adj_a[k]),
      .b   (adj_b[k]),
      .p   (p_adj[k])
    );
  end

  // ---------------------------------------------------------------- stage 6
  always_ff @(posedge clk) begin
    if (en[S6]) begin
      side2[0].w     <= side1[MUL_LAT].w;
      side2[0].t     <= side1[MUL_LAT].t;
      side2[0].a     <= side1[MUL_LAT].a;
      side2[0].b     <= side1[MUL_LAT].b;
      side2[0].c     <= side1[MUL_LAT].c;
      side2[0].d     <= side1[MUL_LAT].d;
      side2[0].e     <= side1[MUL_LAT].e;
      side2[0].dmode <= side1[MUL_LAT].dmode;
      for (int i = 0; i < 3; i++) begin
        side2[0].iw[i] <= IWW'(p_iw[i][0]) + IWW'(p_iw[i][1]) + IWW'(p_iw[i][2]);
      end
      for (int k = 0; k < 6; k++) begin
        side2[0].adj[k] <= ADW'(p_adj[2*k]) - ADW'(p_adj[2*k+1]);
      end
    end
    for (int s = 1; s <= MUL_LAT; s++) begin
      if (en[G2+s-1]) side2[s] <= side2[s-1];
    end
  end

  // ---------------------------------------------------------------- group 2
  for (genvar k = 0; k < 6; k++) begin : g_cross
    rbaa_mul #(.AW(DW), .BW(IWW)) u_mul (
      .clk (clk),
      .en  (en[G2 +: MUL_LAT]),
      .a   (side2[0].w[CW_IDX[k]]),
      .b   (side2[0].iw[CI_IDX[k]]),
      .p   (p_cr[k])
    );
  end

  rbaa_mul #(.AW(MW), .BW(ADW)) u_det0 (
    .clk (clk),
    .en  (en[G2 +: MUL_LAT]),
    .a   (side2[0].a),
    .b   (side2[0].adj[0]),
    .p   (p_det[0])
  );

  rbaa_mul #(.AW(MW), .BW(ADW)) u_det1 (
    .clk (clk),
    .en  (en[G2 +: MUL_LAT]),
    .a   (side2[0].d),
    .b   (side2[0].adj[3]),
    .p   (p_det[1])
  );

  rbaa_mul #(.AW(MW), .BW(ADW)) u_det2 (
    .clk (clk),
    .en  (en[G2 +: MUL_LAT]),
    .a   (side2[0].e),
    .b   (side2[0].adj[4]),
    .p   (p_det[2])
  );

  // ---------------------------------------------------------------- stage 12
  always_ff @(posedge clk) begin
    if (en[S12]) begin
      for (int i = 0; i < 3; i++) begin
        side3[0].rhs[i] <= (RHW'(side2[MUL_LAT].t[i]) <<< (2 * FB))
                           - RHW'(p_cr[2*i]) + RHW'(p_cr[2*i+1]);
      end
      side3[0].adj   <= side2[MUL_LAT].adj;
      side3[0].det   <= DTW'(p_det[0]) + DTW'(p_det[1]) + DTW'(p_det[2]);
      side3[0].a     <= side2[MUL_LAT].a;
      side3[0].b     <= side2[MUL_LAT].b;
      side3[0].c     <= side2[MUL_LAT].c;
      side3[0].dmode <= side2[MUL_LAT].dmode;
    end
    for (int s = 1; s <= MUL_LAT; s++) begin
      if (en[G3+s-1]) side3[s] <= side3[s-1];
    end
  end

  // ---------------------------------------------------------------- group 3
  for (genvar i = 0; i < 3; i++) begin : g_n_row
    for (genvar j = 0; j < 3; j++) begin : g_n_col
      rbaa_mul #(.AW(ADW), .BW(RHW)) u_mul (
        .clk (clk),
        .en  (en[G3 +: MUL_LAT]),
        .a   (side3[0].adj[ADJ_IDX[i][j]]),
        .b   (side3[0].rhs[j]),
        .p   (p_n[i][j])
      );
    end
  end

  // ---------------------------------------------------------------- stage 18
  // Diagonal modes divide each right-hand side by its own moment; the coupled
  // modes divide the adjugate product by the determinant.
  always_ff @(posedge clk) begin
    if (en[S18]) begin
      for (int i = 0; i < 3; i++) begin
        if (side3[MUL_LAT].dmode) begin
          st18.num[i] <= NW'(side3[MUL_LAT].rhs[i]);
        end else begin
          st18.num[i] <= NW'(p_n[i][0]) + NW'(p_n[i][1]) + NW'(p_n[i][2]);
        end
      end
      if (side3[MUL_LAT].dmode) begin
        st18.den[0] <= DTW'(side3[MUL_LAT].a);
        st18.den[1] <= DTW'(side3[MUL_LAT].b);
        st18.den[2] <= DTW'(side3[MUL_LAT].c);
      end else begin
        for (int i = 0; i < 3; i++) st18.den[i] <= side3[MUL_LAT].det;
      end
    end
  end

  // ---------------------------------------------------------------- dividers
  for (genvar i = 0; i < 3; i++) begin : g_div
    rbaa_div #(.DW(DW), .FB(FB), .NW(NW), .DNW(DTW)) u_div (
      .clk   (clk),
      .en    (en[GD +: DIV_LAT]),
      .num   (st18.num[i]),
      .den   (st18.den[i]),
      .quo   (quo[i]),
      .fault (flt[i])
    );
  end

  assign alpha_x      = quo[0];
  assign alpha_y      = quo[1];
  assign alpha_z      = quo[2];
  assign divide_fault = |flt;

  // ---------------------------------------------------------------- checks
  ap_accept_enters: assert property (@(posedge clk) disable iff (rst)
    (item_valid && item_ready) |=> v[0])
    else $error("accepted item did not enter the first stage");

  ap_ready_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !item_ready |-> ((&v) && !result_ready))
    else $error("item_ready low while the pipeline has room");

  ap_div_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (v[GD] && !en[GD]) |=> v[GD])
    else $error("stalled divider entry stage lost its item");

endmodule
